[src/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the byte FIFO with frame counting.
// ----------------------------------------------------------------------------
package bfc_pkg;

   typedef logic [1:0] op_type;
   typedef logic [7:0] byte_type;
   typedef logic [8:0] count_type;

   // Operation codes carried in the op field of a request item.
   localparam op_type OP_PUT   = 2'd0;
   localparam op_type OP_GET   = 2'd1;
   localparam op_type OP_CLEAN = 2'd2;

   // Result status codes.
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // Configuration register map.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_DELIM = 3'd0;
   localparam byte_type DELIM_RESET = 8'd10;

endpackage

[src/bfc_if.sv]
// ----------------------------------------------------------------------------
// bfc_if
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface bfc_req_if import bfc_pkg::*; ();
   logic     valid;
   logic     ready;
   op_type   op;
   byte_type data_in;

   modport source (output valid, output op, output data_in, input ready);
   modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface bfc_rsp_if import bfc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      status;
   byte_type  data_out;
   count_type fill_count;
   logic      is_empty;
   logic      is_full;
   logic      frame_ready;

   modport source (output valid, output status, output data_out, output fill_count,
                   output is_empty, output is_full, output frame_ready, input ready);
   modport sink   (input valid, input status, input data_out, input fill_count,
                   input is_empty, input is_full, input frame_ready, output ready);
endinterface

[src/bfc_csr.sv]
// ----------------------------------------------------------------------------
// bfc_csr
// APB register slice holding the frame delimiter byte.
// ----------------------------------------------------------------------------
module bfc_csr import bfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output byte_type              delim
);

   byte_type delim_ff;
   byte_type delim_in;
   logic     hit;

   // The low two address bits do not take part in decode.
   assign hit = (csr_paddr[CSR_ADDR_W-1:2] == CSR_ADDR_DELIM[CSR_ADDR_W-1:2]);

   always_comb begin
      delim_in = delim_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         delim_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else begin
         delim_ff <= delim_in;
      end
   end

   assign csr_prdata = hit ? {24'd0, delim_ff} : 32'd0;
   assign csr_pready = 1'b1;
   assign delim      = delim_ff;

endmodule

[src/bfc_store.sv]
// ----------------------------------------------------------------------------
// bfc_store
// Byte storage array with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfc_store import bfc_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  byte_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output byte_type      rd_data
);

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data only moves on a read so it holds while the result is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/byte_fifo_with_frame_count_core.sv]
// ----------------------------------------------------------------------------
// byte_fifo_with_frame_count_core
// Receive-side byte FIFO that also counts frame delimiters in and out.
// ----------------------------------------------------------------------------
// Usage: each request item on req_ch carries an op (put, get or clean) and a
// byte. Every accepted item produces exactly one response item on rsp_ch with
// the status, the byte removed by a get, and the fill level, empty, full and
// frame-available flags as they stand after that operation.
// The response of an item accepted at a clock edge is presented from the
// cycle after it on. One item is taken per cycle while the receiver does
// not stall the response register.
// The response sits in an output register; req_ch.ready is high whenever that
// register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the response and back-pressures the request side.
// Reset clears both pointers, both frame counters and the response register,
// and sets the delimiter to newline. The byte store is not cleared; a get only
// ever reads entries written since reset, so no clearing pass is needed.
// The delimiter register sits at byte address 0 of the APB-style csr_ port.
// ----------------------------------------------------------------------------
module byte_fifo_with_frame_count_core import bfc_pkg::*; #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   bfc_req_if.sink               req_ch,
   bfc_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Pointers count modulo twice the depth so that full and empty differ.
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned PW = $clog2(2 * DEPTH);
   localparam int unsigned FW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST  = PW'(2 * DEPTH - 1);
   localparam logic [PW-1:0] PTR_DEPTH = PW'(DEPTH);
   localparam logic [PW:0]   PTR_SPAN  = (PW + 1)'(2 * DEPTH);
   localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
      logic [PW-1:0] s;
      s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
      return s[AW-1:0];
   endfunction

   byte_type delim;

   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   byte_type      frames_in_ff, frames_in_in;
   byte_type      frames_out_ff, frames_out_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          status_ff, status_in;
   logic          got_ff, got_in;
   logic          bump_pending_ff, bump_pending_in;

   logic          accept;
   logic [PW:0]   fill_wide;
   logic [FW-1:0] fill;
   logic [FW+8:0] fill_ext;
   logic          empty;
   logic          full;
   logic          put_ok;
   logic          get_ok;
   logic          clean_ok;
   byte_type      rd_data;
   byte_type      frames_out_eff;

   bfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .delim       (delim)
   );

   bfc_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (put_ok),
      .wr_addr (ptr_slot(wptr_ff)),
      .wr_data (req_ch.data_in),
      .rd_en   (get_ok),
      .rd_addr (ptr_slot(rptr_ff)),
      .rd_data (rd_data)
   );

   // The pointers only move when an item is accepted, so the fill level taken
   // from the pointer registers is at once the level seen by the next item and
   // the level after the item whose response is currently held.
   assign fill_wide = (wptr_ff >= rptr_ff) ? {1'b0, wptr_ff} - {1'b0, rptr_ff}
                                           : {1'b0, wptr_ff} + PTR_SPAN - {1'b0, rptr_ff};
   assign fill      = fill_wide[FW-1:0];
   assign empty     = (fill == '0);
   assign full      = (fill == FILL_FULL);

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      put_ok    = 1'b0;
      get_ok    = 1'b0;
      clean_ok  = 1'b0;
      status_in = STATUS_DONE;
      unique case (req_ch.op)
         OP_PUT: begin
            put_ok    = accept && !full;
            status_in = full ? STATUS_REJECTED : STATUS_DONE;
         end
         OP_GET: begin
            get_ok    = accept && !empty;
            status_in = empty ? STATUS_REJECTED : STATUS_DONE;
         end
         OP_CLEAN: begin
            clean_ok = accept;
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   // The byte removed by a get arrives from the store's read register in the
   // cycle after the get, so the matching bump of the outgoing frame counter
   // is held as a pending term and folded into the counter at the following edge.
   assign frames_out_eff = frames_out_ff
                         + byte_type'(bump_pending_ff && (rd_data == delim));

   always_comb begin
      wptr_in         = put_ok ? ptr_next(wptr_ff) : wptr_ff;
      rptr_in         = get_ok ? ptr_next(rptr_ff) : (clean_ok ? wptr_ff : rptr_ff);
      frames_in_in    = frames_in_ff
                      + byte_type'(put_ok && (req_ch.data_in == delim));
      frames_out_in   = frames_out_eff;
      bump_pending_in = get_ok;
      got_in          = accept ? get_ok : got_ff;
      rsp_valid_in    = accept ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff         <= '0;
         rptr_ff         <= '0;
         frames_in_ff    <= '0;
         frames_out_ff   <= '0;
         bump_pending_ff <= 1'b0;
         got_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         wptr_ff         <= wptr_in;
         rptr_ff         <= rptr_in;
         frames_in_ff    <= frames_in_in;
         frames_out_ff   <= frames_out_in;
         bump_pending_ff <= bump_pending_in;
         got_ff          <= got_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // The fill count port is nine bits; deeper configurations keep the low bits.
   assign fill_ext = {9'd0, fill};

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.data_out    = got_ff ? rd_data : 8'd0;
   assign rsp_ch.fill_count  = fill_ext[8:0];
   assign rsp_ch.is_empty    = empty;
   assign rsp_ch.is_full     = full;
   assign rsp_ch.frame_ready = (frames_in_ff != frames_out_eff);

endmodule

[test/byte_fifo_with_frame_count_core_tb.sv]
// ----------------------------------------------------------------------------
// byte_fifo_with_frame_count_core_tb
// Self-checking bench for the byte FIFO with frame counting. A queue of put,
// get, clean and no-op items feeds a valid/ready driver, a shadow copy of the
// FIFO works out each response, and a monitor compares every response item
// field by field while the delimiter register is changed between phases.
// ----------------------------------------------------------------------------
module byte_fifo_with_frame_count_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfc_pkg::*;

   localparam int unsigned FIFO_DEPTH   = 256;
   localparam int unsigned STALL_LIMIT  = 200;
   // The op field has one spare code; the block must treat it as a no-op.
   localparam op_type      OP_NOP       = 2'd3;

   typedef struct packed {
      op_type   op;
      byte_type data;
   } fifo_request_type;

   typedef struct packed {
      logic      status;
      byte_type  data_out;
      count_type fill_count;
      logic      is_empty;
      logic      is_full;
      logic      frame_ready;
   } fifo_result_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bfc_req_if req_ch ();
   bfc_rsp_if rsp_ch ();

   byte_fifo_with_frame_count_core #(
      .DEPTH (FIFO_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Items still to be offered on the request channel, and the responses
   // that accepted items have yet to produce, oldest first.
   fifo_request_type queued_requests[$];
   fifo_result_type  awaited_results[$];

   // Shadow copy of the FIFO contents, its pointers and its frame counters.
   // The pointers run modulo twice the depth, exactly like the hardware.
   byte_type    shadow_bytes [FIFO_DEPTH];
   int unsigned wr_ptr;
   int unsigned rd_ptr;
   logic [7:0]  frames_in;
   logic [7:0]  frames_out;
   byte_type    delimiter;

   int          mismatches;
   int unsigned idle_cycles;
   int unsigned req_gap;
   int unsigned rsp_gap;
   int unsigned planned_fill;
   bit          req_taken;
   bit          rsp_taken;
   bit          quiet;

   // The clock period is 2 ns.
   always #1 clock = ~clock;

   function automatic int unsigned held_bytes();
      return (wr_ptr + 2 * FIFO_DEPTH - rd_ptr) % (2 * FIFO_DEPTH);
   endfunction

   // Applies one operation to the shadow FIFO and returns the response that
   // the block has to produce for it.
   function automatic fifo_result_type step_fifo(op_type op, byte_type data);
      fifo_result_type res;
      int unsigned     level;
      res        = '0;
      res.status = STATUS_DONE;
      level      = held_bytes();
      case (op)
         OP_PUT: begin
            if (level >= FIFO_DEPTH) begin
               res.status = STATUS_REJECTED;
            end else begin
               shadow_bytes[wr_ptr % FIFO_DEPTH] = data;
               wr_ptr = (wr_ptr + 1) % (2 * FIFO_DEPTH);
               if (data == delimiter) frames_in = frames_in + 8'd1;
            end
         end
         OP_GET: begin
            if (level == 0) begin
               res.status = STATUS_REJECTED;
            end else begin
               res.data_out = shadow_bytes[rd_ptr % FIFO_DEPTH];
               rd_ptr = (rd_ptr + 1) % (2 * FIFO_DEPTH);
               if (res.data_out == delimiter) frames_out = frames_out + 8'd1;
            end
         end
         OP_CLEAN: begin
            // Clean drops the contents but leaves the frame counters alone.
            rd_ptr = wr_ptr;
         end
         default: begin
         end
      endcase
      level           = held_bytes();
      res.fill_count  = count_type'(level);
      res.is_empty    = (level == 0);
      res.is_full     = (level == FIFO_DEPTH);
      res.frame_ready = (frames_in != frames_out);
      return res;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Queues one item and keeps a rough fill level so that the stimulus
   // phases know when the FIFO is full or empty.
   task automatic add_request(op_type op, byte_type data);
      fifo_request_type item;
      item.op   = op;
      item.data = data;
      queued_requests.push_back(item);
      case (op)
         OP_PUT:   if (planned_fill < FIFO_DEPTH) planned_fill++;
         OP_GET:   if (planned_fill > 0) planned_fill--;
         OP_CLEAN: planned_fill = 0;
         default:  ;
      endcase
   endtask

   // Half of the bytes equal the delimiter, so frames come often and the
   // 8-bit frame counters wrap.
   function automatic byte_type frame_byte();
      return ($urandom_range(0, 1) == 0) ? delimiter : byte_type'($urandom);
   endfunction

   task automatic fill_to_full(int unsigned extra);
      while (planned_fill < FIFO_DEPTH) add_request(OP_PUT, frame_byte());
      // Puts into a full FIFO must be rejected.
      repeat (extra) add_request(OP_PUT, byte_type'($urandom));
   endtask

   task automatic mixed_traffic(int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      add_request(OP_PUT, frame_byte());
         else if (pick < 90) add_request(OP_GET, byte_type'($urandom));
         else if (pick < 96) add_request(OP_CLEAN, byte_type'($urandom));
         else                add_request(OP_NOP, byte_type'($urandom));
      end
   endtask

   // Waits until every queued item has gone through and every response is in.
   // Each item yields one response.
   task automatic settle();
      @(negedge clock);
      while (queued_requests.size() != 0 || awaited_results.size() != 0 || req_ch.valid)
         @(negedge clock);
      repeat (2) @(negedge clock);
      planned_fill = held_bytes();
   endtask

   task automatic write_delimiter(byte_type value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_DELIM;
      csr_pwdata  = {24'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      delimiter   = value;
   endtask

   // Request driver. A new item is presented only once the previous one has
   // been taken; random gaps fall between items unless quiet is set.
   always @(negedge clock) begin : request_driver
      fifo_request_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(1, 11) - 1;
            req_ch.valid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            next_item = queued_requests.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.op      <= next_item.op;
            req_ch.data_in <= next_item.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response receiver. It stalls in random bursts, which in turn holds
   // back the request side through the output register.
   always @(negedge clock) begin : response_stall
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 11) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor. Responses are checked before the item accepted at the same
   // edge is predicted, since that item's response comes in a later cycle.
   always @(posedge clock) begin : monitor
      fifo_result_type want;
      if (reset) begin
         req_taken   = 1'b0;
         rsp_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         rsp_taken = rsp_ch.valid && rsp_ch.ready;
         if (rsp_taken) begin
            if (awaited_results.size() == 0) begin
               $display("%0t ns: unexpected response item, expected none, got status %0d data %0d fill %0d",
                        $time, rsp_ch.status, rsp_ch.data_out, rsp_ch.fill_count);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("data_out", want.data_out, rsp_ch.data_out);
               check_field("fill_count", want.fill_count, rsp_ch.fill_count);
               check_field("is_empty", want.is_empty, rsp_ch.is_empty);
               check_field("is_full", want.is_full, rsp_ch.is_full);
               check_field("frame_ready", want.frame_ready, rsp_ch.frame_ready);
            end
         end
         if (req_taken) awaited_results.push_back(step_fifo(req_ch.op, req_ch.data_in));
         // The watchdog only counts cycles in which neither channel moves.
         if (req_taken || rsp_taken) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("byte_fifo_with_frame_count_core_tb NOT OK");
               $finish;
            end
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_PUT;
      req_ch.data_in = '0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      wr_ptr         = 0;
      rd_ptr         = 0;
      frames_in      = '0;
      frames_out     = '0;
      delimiter      = DELIM_RESET;
      mismatches     = 0;
      req_gap        = 0;
      rsp_gap        = 0;
      planned_fill   = 0;
      quiet          = 1'b0;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, run with the delimiter at its reset value (newline).
      // A get on an empty FIFO, the spare op code, then a clean on an empty FIFO.
      add_request(OP_GET, 8'h00);
      add_request(OP_NOP, 8'hFF);
      add_request(OP_CLEAN, 8'h00);
      // A stored delimiter makes a frame available; taking it out ends that.
      add_request(OP_PUT, DELIM_RESET);
      add_request(OP_PUT, 8'h00);
      add_request(OP_PUT, 8'hFF);
      add_request(OP_GET, 8'h00);
      // Clean empties the FIFO while the frame counters still differ, so the
      // frame flag stays up, also across a rejected get.
      add_request(OP_PUT, DELIM_RESET);
      add_request(OP_CLEAN, 8'hFF);
      add_request(OP_GET, 8'hFF);
      add_request(OP_PUT, 8'h55);
      add_request(OP_PUT, 8'hAA);
      add_request(OP_NOP, 8'h00);
      add_request(OP_GET, 8'h00);
      add_request(OP_GET, 8'h00);
      // A delimiter that goes in and out leaves the counters as far apart as before.
      add_request(OP_PUT, DELIM_RESET);
      add_request(OP_GET, 8'h00);
      add_request(OP_CLEAN, 8'h00);
      settle();

      // Lowest delimiter: fill the FIFO to the brim and push past it.
      write_delimiter(8'h00);
      fill_to_full(3);
      settle();

      // Highest delimiter with mixed traffic starting from a full FIFO.
      write_delimiter(8'hFF);
      mixed_traffic(80);
      settle();

      // Drain everything, including gets on an empty FIFO.
      write_delimiter(byte_type'($urandom));
      while (planned_fill > 0) add_request(OP_GET, byte_type'($urandom));
      add_request(OP_GET, byte_type'($urandom));
      add_request(OP_GET, byte_type'($urandom));
      settle();

      write_delimiter(byte_type'($urandom));
      mixed_traffic(80);
      settle();

      // Last phase at full speed on both sides: fill up again, which also
      // carries the write pointer around its wrap.
      write_delimiter(DELIM_RESET);
      quiet = 1'b1;
      fill_to_full(2);
      mixed_traffic(40);
      settle();

      if (mismatches == 0) begin
         $display("byte_fifo_with_frame_count_core_tb OK");
      end else begin
         $display("byte_fifo_with_frame_count_core_tb NOT OK");
      end
      $finish;
   end

endmodule

[byte_fifo_with_frame_count_core.f]
src/bfc_pkg.sv
src/bfc_if.sv
src/bfc_csr.sv
src/bfc_store.sv
src/byte_fifo_with_frame_count_core.sv
test/byte_fifo_with_frame_count_core_tb.sv
